// ===== src/cpst_pkg.sv =====
// Shared types and constants of the contact point set table.
// Used by the interfaces, the scan unit, the top level and the testbench.
package cpst_pkg;

    localparam int CPST_MAX_POINTS = 8;
    localparam int CPST_NUM_LINKS  = 8;
    localparam int CPST_NUM_STEPS  = 32;

    localparam int COORD_W = 24;
    localparam int ELEM_W  = 4;
    localparam int RAD_W   = 23;
    localparam int R2_W    = 2 * RAD_W;
    localparam int SUM_W   = 52;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_SETDIST = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_EVICT = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic CFG_DEDUP  = 1'b0;
    localparam logic CFG_SPHERE = 1'b1;

    localparam logic [RAD_W-1:0] DEDUP_RST  = 23'd3277;
    localparam logic [RAD_W-1:0] SPHERE_RST = 23'd6554;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] distance;
        logic [ELEM_W-1:0]         elem;
    } t_entry;

    typedef struct packed {
        logic dup;
        logic busy;
    } t_scan_st;

endpackage

// ===== src/cpst_if.sv =====
// Request and response channel interfaces of the contact point set table.
// Depends on cpst_pkg for field widths.
interface cpst_req_if import cpst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [2:0]                link_index;
    logic [4:0]                step_index;
    logic [2:0]                slot_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] penetration;
    logic signed [COORD_W-1:0] new_distance;
    logic [ELEM_W-1:0]         element_id;

    modport source (output valid, opcode, link_index, step_index, slot_index, point_x,
                    point_y, point_z, penetration, new_distance, element_id,
                    input ready);
    modport sink (input valid, opcode, link_index, step_index, slot_index, point_x,
                  point_y, point_z, penetration, new_distance, element_id,
                  output ready);
endinterface

interface cpst_rsp_if import cpst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [3:0]                set_count;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] out_distance;
    logic [ELEM_W-1:0]         out_element;

    modport source (output valid, status, set_count, out_x, out_y, out_z, out_distance,
                    out_element, input ready);
    modport sink (input valid, status, set_count, out_x, out_y, out_z, out_distance,
                  out_element, output ready);
endinterface

// ===== src/cpst_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// Depends on nothing beyond its parameters.
module cpst_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                            o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/cpst_scan.sv =====
// Duplicate and eviction scan over the entries of one set, two stages deep.
// Depends on cpst_pkg for the entry type and widths.
module cpst_scan import cpst_pkg::*; #(
    parameter int CNT_W = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_valid,
    input  logic [CNT_W-1:0]          i_idx,
    input  t_entry                    i_entry,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic signed [COORD_W-1:0] i_pz,
    input  logic [R2_W-1:0]           i_r2,
    output t_scan_st                  o_st,
    output logic [CNT_W-1:0]          o_best
);
    logic signed [COORD_W:0]    dx, dy, dz;
    logic signed [2*COORD_W+1:0] n_sqx, n_sqy, n_sqz;
    logic [SUM_W-1:0]           sum;
    logic [2*COORD_W+1:0]       r_sqx, r_sqy, r_sqz;
    logic                       r_va;
    logic                       r_dup;
    logic [CNT_W-1:0]           r_best;
    logic signed [COORD_W-1:0]  r_best_d;

    assign dx = {i_px[COORD_W-1], i_px} - {i_entry.x[COORD_W-1], i_entry.x};
    assign dy = {i_py[COORD_W-1], i_py} - {i_entry.y[COORD_W-1], i_entry.y};
    assign dz = {i_pz[COORD_W-1], i_pz} - {i_entry.z[COORD_W-1], i_entry.z};
    assign n_sqx = dx * dx;
    assign n_sqy = dy * dy;
    assign n_sqz = dz * dz;
    assign sum = SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);

    always_ff @(posedge i_clk) begin
        r_sqx <= n_sqx;
        r_sqy <= n_sqy;
        r_sqz <= n_sqz;
        if (i_valid && ((i_idx == '0) || (i_entry.distance > r_best_d))) begin
            r_best   <= i_idx;
            r_best_d <= i_entry.distance;
        end
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_dup <= 1'b0;
        end else begin
            r_va <= i_valid;
            if (i_start) begin
                r_dup <= 1'b0;
            end else if (r_va && (sum < SUM_W'(i_r2))) begin
                r_dup <= 1'b1;
            end
        end
    end

    assign o_st.dup  = r_dup;
    assign o_st.busy = r_va;
    assign o_best    = r_best;
endmodule

// ===== src/contact_point_set_table.sv =====
// Top level of the contact point set table: control sequencer, count and entry RAMs.
// Depends on cpst_pkg, cpst_if, cpst_ram and cpst_scan.
//
// Channel  | Direction | Handshake        | Carries
// i_req    | in        | valid/ready      | opcode, set address, slot, point, distances
// o_rsp    | out       | valid/ready      | status, set count, entry read back
// i_cfg_*  | in        | write enable     | dedup radius (index 0), sphere radius (1)
//
// A read or set-distance passes through the count, read-modify-write and output states,
// a clear through the count and output states. An insert scans every stored entry for a
// duplicate, then appends; on eviction the entries behind the evicted one first shift down.
// After reset a clearing pass zeroes every set count, one per cycle, before the first
// request transfer. The result sits in an output register, so a new request is taken while
// it waits; a stalled result only holds the next one back.
module contact_point_set_table import cpst_pkg::*; #(
    parameter int MAX_POINTS = CPST_MAX_POINTS,
    parameter int NUM_LINKS  = CPST_NUM_LINKS,
    parameter int NUM_STEPS  = CPST_NUM_STEPS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [RAD_W-1:0] i_cfg_data,
    cpst_req_if.sink         i_req,
    cpst_rsp_if.source       o_rsp
);
    localparam int NUM_SETS = NUM_LINKS * NUM_STEPS;
    localparam int NUM_ENT  = NUM_SETS * MAX_POINTS;
    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int ENT_W    = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);

    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CNT   = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_APP   = 8'b0010_0000,
        S_RMW   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // Configuration registers and the squared duplicate radius derived from the dedup radius.
    logic [RAD_W-1:0] r_dedup, r_sphere;
    logic [R2_W-1:0]  r_r2;

    // Latched request.
    logic [1:0]                r_op;
    logic [2:0]                r_slot;
    logic signed [COORD_W-1:0] r_px, r_py, r_pz, r_newd;
    logic [COORD_W:0]          r_dsum;
    logic [ELEM_W-1:0]         r_elem;
    logic [SET_W-1:0]          r_set;
    logic [ENT_W-1:0]          r_base;

    // Sequencer counters.
    logic [SET_W-1:0] r_clr;
    logic [CNT_W-1:0] r_cnt, r_rd_idx, r_i1, r_app;
    logic             r_v1;

    // Result being assembled, and the output register.
    logic [2:0]  r_status;
    logic [CNT_W-1:0] r_rcnt;
    t_entry      r_rdata;
    logic        r_ov;
    logic [2:0]  r_o_status;
    logic [3:0]  r_o_cnt;
    t_entry      r_o_data;

    logic             accept, in_range, slot_ok, scan_idle, out_free;
    logic [SET_W-1:0] set_c;
    logic [ENT_W-1:0] base_c;

    logic             cnt_we;
    logic [SET_W-1:0] cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0] cnt_wdata, cnt_q;
    logic             ent_we;
    logic [ENT_W-1:0] ent_waddr, ent_raddr;
    t_entry           ent_wdata, ent_q, app_entry;
    logic signed [COORD_W-1:0] dsat;

    t_scan_st         scan_st;
    logic [CNT_W-1:0] scan_best;
    logic             scan_start;

    assign accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign in_range = (int'(i_req.link_index) < NUM_LINKS) &&
                      (int'(i_req.step_index) < NUM_STEPS);
    assign set_c    = SET_W'(int'(i_req.link_index) * NUM_STEPS + int'(i_req.step_index));
    assign base_c   = ENT_W'(int'(set_c) * MAX_POINTS);
    assign slot_ok  = (int'(r_slot) < int'(cnt_q));
    assign scan_idle = (r_rd_idx == r_cnt) && !r_v1 && !scan_st.busy;
    assign out_free = !r_ov || o_rsp.ready;
    assign scan_start = (r_state == S_CNT);

    // Penetration plus sphere radius, saturated to the 24-bit signed range.
    always_comb begin
        if (r_dsum[COORD_W] != r_dsum[COORD_W-1]) begin
            dsat = r_dsum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            dsat = r_dsum[COORD_W-1:0];
        end
        app_entry.x        = r_px;
        app_entry.y        = r_py;
        app_entry.z        = r_pz;
        app_entry.distance = dsat;
        app_entry.elem     = r_elem;
    end

    // Count RAM port control: clearing pass, clear opcode and the count after an insert.
    always_comb begin
        cnt_raddr = (r_state == S_IDLE) ? set_c : r_set;
        cnt_we    = 1'b0;
        cnt_waddr = r_set;
        cnt_wdata = '0;
        case (r_state)
            S_CLR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
            end
            S_CNT: begin
                cnt_we = (r_op == OP_CLEAR);
            end
            S_APP: begin
                cnt_we    = 1'b1;
                cnt_wdata = r_app + 1'b1;
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // Entry RAM port control. Shift writes trail the reads by one slot, so they never
    // touch an entry that is still to be read.
    always_comb begin
        ent_raddr = r_base + ENT_W'((r_state == S_CNT) ? CNT_W'(r_slot) : r_rd_idx);
        ent_we    = 1'b0;
        ent_waddr = r_base + ENT_W'(r_app);
        ent_wdata = app_entry;
        case (r_state)
            S_SHIFT: begin
                ent_we    = r_v1;
                ent_waddr = r_base + ENT_W'(r_i1 - 1'b1);
                ent_wdata = ent_q;
            end
            S_APP: begin
                ent_we = 1'b1;
            end
            S_RMW: begin
                ent_we             = (r_op == OP_SETDIST);
                ent_waddr          = r_base + ENT_W'(r_slot);
                ent_wdata          = ent_q;
                ent_wdata.distance = r_newd;
            end
            default: begin
                ent_we = 1'b0;
            end
        endcase
    end

    cpst_ram #(.W(CNT_W), .DEPTH(NUM_SETS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

    cpst_ram #(.W($bits(t_entry)), .DEPTH(NUM_ENT)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_q)
    );

    cpst_scan #(.CNT_W(CNT_W)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_valid (r_v1 && (r_state == S_SCAN)),
        .i_idx   (r_i1),
        .i_entry (ent_q),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_pz    (r_pz),
        .i_r2    (r_r2),
        .o_st    (scan_st),
        .o_best  (scan_best)
    );

    always_ff @(posedge i_clk) begin
        r_r2 <= R2_W'(r_dedup * r_dedup);

        if (accept) begin
            r_op   <= i_req.opcode;
            r_slot <= i_req.slot_index;
            r_px   <= i_req.point_x;
            r_py   <= i_req.point_y;
            r_pz   <= i_req.point_z;
            r_newd <= i_req.new_distance;
            r_dsum <= {i_req.penetration[COORD_W-1], i_req.penetration} +
                      {2'b00, r_sphere};
            r_elem <= i_req.element_id;
            r_set  <= set_c;
            r_base <= base_c;
            r_status <= ST_DONE;
            r_rcnt   <= '0;
            r_rdata  <= '0;
        end

        // Read pipeline shared by the duplicate scan and the eviction shift. Once the
        // scan has drained, the valid flag is already low here.
        if ((r_state == S_SCAN) || (r_state == S_SHIFT)) begin
            r_v1 <= (r_rd_idx != r_cnt);
            r_i1 <= r_rd_idx;
            if (r_rd_idx != r_cnt) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end

        case (r_state)
            S_CNT: begin
                r_cnt    <= cnt_q;
                r_rcnt   <= (r_op == OP_CLEAR) ? '0 : cnt_q;
                r_rd_idx <= '0;
                r_v1     <= 1'b0;
                r_app    <= cnt_q;
                case (r_op)
                    OP_INSERT:  r_status <= ST_ADDED;
                    OP_CLEAR:   r_status <= ST_DONE;
                    default:    r_status <= slot_ok ? ST_DONE : ST_EMPTY;
                endcase
            end
            S_SCAN: begin
                if (scan_idle) begin
                    if (scan_st.dup) begin
                        r_status <= ST_DUP;
                    end else if (int'(r_cnt) >= MAX_POINTS) begin
                        r_rd_idx <= scan_best + 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                if ((r_rd_idx == r_cnt) && !r_v1) begin
                    r_app    <= r_cnt - 1'b1;
                    r_status <= ST_EVICT;
                end
            end
            S_APP: begin
                r_rcnt <= r_app + 1'b1;
            end
            S_RMW: begin
                if (r_op == OP_READ) begin
                    r_rdata <= ent_q;
                end
            end
            default: begin
            end
        endcase

        if ((r_state == S_OUT) && out_free) begin
            r_o_status <= r_status;
            r_o_cnt    <= 4'(r_rcnt);
            r_o_data   <= r_rdata;
        end

        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ov     <= 1'b0;
            r_dedup  <= DEDUP_RST;
            r_sphere <= SPHERE_RST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DEDUP) begin
                    r_dedup <= i_cfg_data;
                end else begin
                    r_sphere <= i_cfg_data;
                end
            end

            if ((r_state == S_OUT) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (int'(r_clr) == NUM_SETS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= in_range ? S_CNT : S_OUT;
                    end
                end
                S_CNT: begin
                    case (r_op)
                        OP_INSERT: r_state <= (cnt_q == '0) ? S_APP : S_SCAN;
                        OP_CLEAR:  r_state <= S_OUT;
                        default:   r_state <= slot_ok ? S_RMW : S_OUT;
                    endcase
                end
                S_SCAN: begin
                    if (scan_idle) begin
                        if (scan_st.dup) begin
                            r_state <= S_OUT;
                        end else if (int'(r_cnt) >= MAX_POINTS) begin
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_APP;
                        end
                    end
                end
                S_SHIFT: begin
                    if ((r_rd_idx == r_cnt) && !r_v1) begin
                        r_state <= S_APP;
                    end
                end
                S_APP:   r_state <= S_OUT;
                S_RMW:   r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.set_count    = r_o_cnt;
    assign o_rsp.out_x        = r_o_data.x;
    assign o_rsp.out_y        = r_o_data.y;
    assign o_rsp.out_z        = r_o_data.z;
    assign o_rsp.out_distance = r_o_data.distance;
    assign o_rsp.out_element  = r_o_data.elem;
endmodule

// ===== verif/tb_contact_point_set_table.sv =====
// Self-checking testbench of the contact point set table.
// Depends on cpst_pkg, cpst_if and the contact_point_set_table RTL.
module tb_contact_point_set_table;
    import cpst_pkg::*;

    localparam int NUM_SETS     = CPST_NUM_LINKS * CPST_NUM_STEPS;
    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_TICKS = 40;

    // One request as the sender sees it.
    typedef struct {
        logic [1:0]                op;
        logic [2:0]                link;
        logic [4:0]                step;
        logic [2:0]                slot;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] pen;
        logic signed [COORD_W-1:0] nd;
        logic [ELEM_W-1:0]         elem;
    } t_cmd;

    // One response as the receiver sees it.
    typedef struct {
        logic [2:0]                status;
        logic [3:0]                count;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] distance;
        logic [ELEM_W-1:0]         elem;
    } t_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [0:0]       i_cfg_idx = CFG_DEDUP;
    logic [RAD_W-1:0] i_cfg_data = '0;

    cpst_req_if req ();
    cpst_rsp_if rsp ();

    contact_point_set_table dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req),
        .o_rsp     (rsp)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the table, kept in step with every accepted request.
    logic [3:0]       shadow_count [NUM_SETS];
    t_entry           shadow_entry [NUM_SETS * CPST_MAX_POINTS];
    logic [RAD_W-1:0] shadow_dedup  = DEDUP_RST;
    logic [RAD_W-1:0] shadow_sphere = SPHERE_RST;

    t_answer pending_answers [$];
    int      error_count   = 0;
    int      send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
    int      rsp_stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
    int      hold_left     = 0;   // cycles of forced receiver hold-off still to run

    initial begin
        req.valid        = 1'b0;
        req.opcode       = OP_READ;
        req.link_index   = '0;
        req.step_index   = '0;
        req.slot_index   = '0;
        req.point_x      = '0;
        req.point_y      = '0;
        req.point_z      = '0;
        req.penetration  = '0;
        req.new_distance = '0;
        req.element_id   = '0;
        rsp.ready        = 1'b0;
        foreach (shadow_count[k]) shadow_count[k] = '0;
        foreach (shadow_entry[k]) shadow_entry[k] = '0;
    end

    // Works out the response to one request and updates the shadow table to match,
    // exactly as the block is meant to do it.
    function automatic t_answer apply_to_shadow(t_cmd c);
        t_answer a;
        int      set_no;
        int      base;
        int      cnt;
        int      best;
        longint  dx, dy, dz, r;
        logic    dup;
        int      d;
        a = '{status: ST_DONE, count: 4'd0, x: '0, y: '0, z: '0, distance: '0, elem: '0};
        if (c.link >= CPST_NUM_LINKS || c.step >= CPST_NUM_STEPS) return a;
        set_no = c.link * CPST_NUM_STEPS + c.step;
        base   = set_no * CPST_MAX_POINTS;
        cnt    = shadow_count[set_no];
        if (cnt > CPST_MAX_POINTS) cnt = CPST_MAX_POINTS;
        case (c.op)
            OP_INSERT: begin
                r   = shadow_dedup;
                dup = 1'b0;
                for (int i = 0; i < cnt; i++) begin
                    dx = longint'(c.px) - longint'(shadow_entry[base + i].x);
                    dy = longint'(c.py) - longint'(shadow_entry[base + i].y);
                    dz = longint'(c.pz) - longint'(shadow_entry[base + i].z);
                    if (dx * dx + dy * dy + dz * dz < r * r) begin
                        dup = 1'b1;
                        break;
                    end
                end
                if (dup) begin
                    a.status = ST_DUP;
                end else begin
                    a.status = ST_ADDED;
                    if (cnt >= CPST_MAX_POINTS) begin
                        // The first entry holding the largest distance makes room.
                        best = 0;
                        for (int i = 1; i < cnt; i++)
                            if (shadow_entry[base + i].distance >
                                shadow_entry[base + best].distance)
                                best = i;
                        for (int i = best; i + 1 < cnt; i++)
                            shadow_entry[base + i] = shadow_entry[base + i + 1];
                        cnt--;
                        a.status = ST_EVICT;
                    end
                    d = int'(c.pen) + int'({1'b0, shadow_sphere});
                    if (d > 8388607) d = 8388607;
                    if (d < -8388608) d = -8388608;
                    shadow_entry[base + cnt].x        = c.px;
                    shadow_entry[base + cnt].y        = c.py;
                    shadow_entry[base + cnt].z        = c.pz;
                    shadow_entry[base + cnt].distance = d[COORD_W-1:0];
                    shadow_entry[base + cnt].elem     = c.elem;
                    cnt++;
                end
            end
            OP_SETDIST: begin
                if (c.slot < cnt) shadow_entry[base + c.slot].distance = c.nd;
                else a.status = ST_EMPTY;
            end
            OP_READ: begin
                if (c.slot < cnt) begin
                    a.x        = shadow_entry[base + c.slot].x;
                    a.y        = shadow_entry[base + c.slot].y;
                    a.z        = shadow_entry[base + c.slot].z;
                    a.distance = shadow_entry[base + c.slot].distance;
                    a.elem     = shadow_entry[base + c.slot].elem;
                end else begin
                    a.status = ST_EMPTY;
                end
            end
            default: cnt = 0;
        endcase
        shadow_count[set_no] = cnt[3:0];
        a.count = cnt[3:0];
        return a;
    endfunction

    // Offers one request, with random idle cycles in front, and records the
    // expected response once the transfer has happened. Called at a falling edge.
    task automatic send_cmd(t_cmd c);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        req.opcode       = c.op;
        req.link_index   = c.link;
        req.step_index   = c.step;
        req.slot_index   = c.slot;
        req.point_x      = c.px;
        req.point_y      = c.py;
        req.point_z      = c.pz;
        req.penetration  = c.pen;
        req.new_distance = c.nd;
        req.element_id   = c.elem;
        req.valid        = 1'b1;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        pending_answers.insert(pending_answers.size(), apply_to_shadow(c));
        @(negedge i_clk);
        req.valid = 1'b0;
    endtask

    function automatic t_cmd make_cmd(logic [1:0] op, int link, int step, int slot,
                                      int px, int py, int pz, int pen, int nd, int elem);
        t_cmd c;
        c.op   = op;
        c.link = link[2:0];
        c.step = step[4:0];
        c.slot = slot[2:0];
        c.px   = px[COORD_W-1:0];
        c.py   = py[COORD_W-1:0];
        c.pz   = pz[COORD_W-1:0];
        c.pen  = pen[COORD_W-1:0];
        c.nd   = nd[COORD_W-1:0];
        c.elem = elem[ELEM_W-1:0];
        return c;
    endfunction

    // Random request. Most traffic lands on a handful of sets and on points close
    // together, so that sets fill up, evict and see duplicates; the rest roams the
    // whole table and the full coordinate range.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 50) c.op = OP_INSERT;
        else if (pick < 65) c.op = OP_SETDIST;
        else if (pick < 92) c.op = OP_READ;
        else c.op = OP_CLEAR;
        if ($urandom_range(99) < 80) begin
            c.link = 3'($urandom_range(1));
            c.step = 5'($urandom_range(1));
        end else begin
            c.link = 3'($urandom);
            c.step = 5'($urandom);
        end
        c.slot = 3'($urandom);
        if ($urandom_range(99) < 60) begin
            c.px = COORD_W'($signed($urandom_range(30000)) - 15000);
            c.py = COORD_W'($signed($urandom_range(30000)) - 15000);
            c.pz = COORD_W'($signed($urandom_range(30000)) - 15000);
        end else begin
            c.px = COORD_W'($urandom);
            c.py = COORD_W'($urandom);
            c.pz = COORD_W'($urandom);
        end
        c.pen  = ($urandom_range(3) == 0) ? COORD_W'($urandom) :
                 COORD_W'($signed($urandom_range(20000)) - 10000);
        c.nd   = ($urandom_range(3) == 0) ? COORD_W'($urandom) :
                 COORD_W'($signed($urandom_range(20000)) - 10000);
        c.elem = ELEM_W'($urandom);
        return c;
    endfunction

    // Waits until every expected response has come back and the block is quiet.
    task automatic drain();
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(logic [0:0] idx, logic [RAD_W-1:0] value);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        if (idx == CFG_DEDUP) shadow_dedup = value;
        else shadow_sphere = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_random(int n);
        repeat (n) send_cmd(random_cmd());
    endtask

    // Hand-picked cases: coordinate extremes, every opcode, duplicates, a full set
    // with tied largest distances, writes and reads of empty slots, saturation.
    task automatic test_directed();
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_SETDIST, 0, 0, 7, 0, 0, 0, 0, 5, 0));
        send_cmd(make_cmd(OP_INSERT, 0, 0, 0, 8388607, 8388607, 8388607, 8388607, 0, 15));
        send_cmd(make_cmd(OP_INSERT, 0, 0, 0, -8388608, -8388608, -8388608, -8388608, 0, 0));
        // Within the radius of the first point: dropped.
        send_cmd(make_cmd(OP_INSERT, 0, 0, 0, 8388600, 8388607, 8388607, 0, 0, 3));
        // Exactly on the radius: kept, since the test is strictly less.
        send_cmd(make_cmd(OP_INSERT, 0, 0, 0, 8388607 - 3277, 8388607, 8388607, 0, 0, 4));
        for (int i = 0; i < 6; i++)
            send_cmd(make_cmd(OP_INSERT, 0, 0, 0, i * 100000, 0, 0, (i % 2) * 500, 0, i));
        // Set is full; the ties at the largest distance decide the eviction.
        send_cmd(make_cmd(OP_INSERT, 0, 0, 0, 0, 2000000, 0, 0, 0, 9));
        send_cmd(make_cmd(OP_SETDIST, 0, 0, 7, 0, 0, 0, 0, -8388608, 0));
        send_cmd(make_cmd(OP_INSERT, 0, 0, 0, 0, 3000000, 0, 0, 0, 10));
        for (int i = 0; i < 8; i++) send_cmd(make_cmd(OP_READ, 0, 0, i, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 7, 31, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_CLEAR, 7, 31, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // Registers at their extremes: no deduplication at all, with the largest sphere radius to
    // drive the distance into saturation, then the largest dedup radius and no sphere radius.
    task automatic test_register_extremes();
        write_reg(CFG_DEDUP, '0);
        write_reg(CFG_SPHERE, '1);
        run_random(80);
        write_reg(CFG_DEDUP, '1);
        write_reg(CFG_SPHERE, '0);
        run_random(60);
        write_reg(CFG_DEDUP, 23'd20000);
        write_reg(CFG_SPHERE, 23'd6554);
        run_random(60);
    endtask

    // Random traffic under each mix of sender and receiver idling.
    task automatic test_idling_mixes();
        send_idle_pct = 0;  rsp_stall_pct = 0;  run_random(230);
        send_idle_pct = 62; rsp_stall_pct = 0;  run_random(230);
        send_idle_pct = 0;  rsp_stall_pct = 62; run_random(230);
        send_idle_pct = 21; rsp_stall_pct = 21; run_random(230);
        send_idle_pct = 0;  rsp_stall_pct = 0;
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the
    // block fills and stalls its input; then the sender waits for a full drain.
    task automatic test_back_pressure();
        hold_left = LONG_HOLD;
        run_random(20);
        drain();
        run_random(20);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_register_extremes();
        test_idling_mixes();
        test_back_pressure();
        drain();
        if (error_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, or a forced hold-off while hold_left runs down.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rsp.ready = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            rsp.ready = ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
        error_count++;
    endtask

    // Checks each response transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected response", 1, 0);
            end else begin
                want = pending_answers.pop_front();
                if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
                if (rsp.set_count !== want.count)
                    report_mismatch("set_count", rsp.set_count, want.count);
                if (rsp.out_x !== want.x) report_mismatch("out_x", rsp.out_x, want.x);
                if (rsp.out_y !== want.y) report_mismatch("out_y", rsp.out_y, want.y);
                if (rsp.out_z !== want.z) report_mismatch("out_z", rsp.out_z, want.z);
                if (rsp.out_distance !== want.distance)
                    report_mismatch("out_distance", rsp.out_distance, want.distance);
                if (rsp.out_element !== want.elem)
                    report_mismatch("out_element", rsp.out_element, want.elem);
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// ===== files.f =====
src/cpst_pkg.sv
src/cpst_if.sv
src/cpst_ram.sv
src/cpst_scan.sv
src/contact_point_set_table.sv
verif/tb_contact_point_set_table.sv
